### rtl/core/bsed_pkg.sv
// ----------------------------------------------------------------------------
// bsed_pkg
// Shared types and constants of the backslash escape decoder.
// ----------------------------------------------------------------------------
package bsed_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned SDataW = 8;
  localparam int unsigned MDataW = 16;
  localparam int unsigned MUserW = 2;

  // one queued request: first result, optional second byte, string end flag
  typedef struct packed {
    logic [7:0] byte0;
    logic       valid0;
    logic       stop0;
    logic [7:0] byte1;
    logic       two;
    logic       fin;
  } bsed_entry_t;

endpackage

### rtl/core/bsed_front.sv
// ----------------------------------------------------------------------------
// bsed_front
// Accepts input bytes, tracks the escape state and emits one queue request
// per input byte that produces results.
// ----------------------------------------------------------------------------
module bsed_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_final_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output bsed_pkg::bsed_entry_t entry_o
);
  import bsed_pkg::*;

  localparam logic [2:0] ModeNormal = 3'd0;
  localparam logic [2:0] ModeEsc    = 3'd1;
  localparam logic [2:0] ModeOct    = 3'd2;
  localparam logic [2:0] ModeHex    = 3'd3;
  localparam logic [2:0] ModeStop   = 3'd4;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChC         = 8'h63;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  localparam logic [7:0] CodeBel = 8'h07;
  localparam logic [7:0] CodeBs  = 8'h08;
  localparam logic [7:0] CodeFf  = 8'h0C;
  localparam logic [7:0] CodeLf  = 8'h0A;
  localparam logic [7:0] CodeCr  = 8'h0D;
  localparam logic [7:0] CodeTab = 8'h09;
  localparam logic [7:0] CodeVt  = 8'h0B;

  localparam logic [1:0] OctLimit = 2'd3;
  localparam logic [1:0] HexLimit = 2'd2;

  logic [2:0] mode_q, mode_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] val_q, val_d;

  logic       accept;
  logic [1:0] num;
  logic [7:0] b0, b1;
  logic       v0, s0;
  logic       is_oct, is_hex;
  logic [3:0] dig;
  logic [1:0] cnt_inc;
  logic [7:0] oct_val, hex_val;
  logic       octal;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_oct = (in_byte_i >= ChZero) && (in_byte_i <= ChSeven);
    is_hex = 1'b1;
    dig    = 4'd0;
    if ((in_byte_i >= ChZero) && (in_byte_i <= ChNine)) begin
      dig = 4'(in_byte_i - ChZero);
    end else if ((in_byte_i >= ChA) && (in_byte_i <= ChF)) begin
      dig = 4'(in_byte_i - ChA + 8'd10);
    end else if ((in_byte_i >= ChUpA) && (in_byte_i <= ChUpF)) begin
      dig = 4'(in_byte_i - ChUpA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign cnt_inc = cnt_q + 2'd1;
  assign oct_val = {val_q[4:0], dig[2:0]};
  assign hex_val = {val_q[3:0], dig};
  assign octal   = (mode_q == ModeOct);

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    num    = 2'd0;
    b0     = 8'h00;
    v0     = 1'b1;
    s0     = 1'b0;
    b1     = in_byte_i;
    unique case (mode_q) inside
      ModeStop: begin
        num = in_final_i ? 2'd1 : 2'd0;
        v0  = 1'b0;
      end
      ModeEsc: begin
        mode_d = ModeNormal;
        num    = 2'd1;
        case (in_byte_i) inside
          ChBackslash: b0 = ChBackslash;
          ChA:         b0 = CodeBel;
          ChB:         b0 = CodeBs;
          ChF:         b0 = CodeFf;
          ChN:         b0 = CodeLf;
          ChR:         b0 = CodeCr;
          ChT:         b0 = CodeTab;
          ChV:         b0 = CodeVt;
          ChC: begin
            mode_d = ModeStop;
            v0     = 1'b0;
            s0     = 1'b1;
          end
          ChZero, ChX: begin
            mode_d = (in_byte_i == ChX) ? ModeHex : ModeOct;
            cnt_d  = 2'd0;
            val_d  = 8'h00;
            num    = in_final_i ? 2'd1 : 2'd0;
          end
          default: begin
            b0  = ChBackslash;
            num = 2'd2;
          end
        endcase
      end
      ModeOct, ModeHex: begin
        if (octal ? is_oct : is_hex) begin
          val_d = octal ? oct_val : hex_val;
          cnt_d = cnt_inc;
          if ((cnt_inc >= (octal ? OctLimit : HexLimit)) || in_final_i) begin
            mode_d = ModeNormal;
            num    = 2'd1;
            b0     = val_d;
          end
        end else begin
          b0 = val_q;
          if ((in_byte_i == ChBackslash) && !in_final_i) begin
            mode_d = ModeEsc;
            num    = 2'd1;
          end else begin
            mode_d = ModeNormal;
            num    = 2'd2;
          end
        end
      end
      default: begin
        if ((in_byte_i == ChBackslash) && !in_final_i) begin
          mode_d = ModeEsc;
        end else begin
          mode_d = ModeNormal;
          num    = 2'd1;
          b0     = in_byte_i;
        end
      end
    endcase
    if (in_final_i) begin
      mode_d = ModeNormal;
      cnt_d  = 2'd0;
      val_d  = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      cnt_q  <= 2'd0;
      val_q  <= 8'h00;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      val_q  <= val_d;
    end
  end

  assign push_o         = accept && (num != 2'd0);
  assign entry_o.byte0  = b0;
  assign entry_o.valid0 = v0;
  assign entry_o.stop0  = s0;
  assign entry_o.byte1  = b1;
  assign entry_o.two    = (num == 2'd2);
  assign entry_o.fin    = in_final_i;

endmodule

### rtl/core/bsed_queue.sv
// ----------------------------------------------------------------------------
// bsed_queue
// Small request queue between the decode front and the output back.
// ----------------------------------------------------------------------------
module bsed_queue #(
  parameter int unsigned Depth = bsed_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bsed_pkg::bsed_entry_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bsed_pkg::bsed_entry_t rdata_o
);
  import bsed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bsed_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/bsed_back.sv
// ----------------------------------------------------------------------------
// bsed_back
// Pops queued requests and drives one or two results through the output
// register.
// ----------------------------------------------------------------------------
module bsed_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  bsed_pkg::bsed_entry_t q_entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 stop_seen_o,
  output logic                 string_end_o,
  output logic                 run_last_o
);
  import bsed_pkg::*;

  logic       out_valid_q;
  logic       pend_q;
  logic [7:0] pend_byte_q;
  logic       pend_fin_q;
  logic [7:0] byte_q;
  logic       bvalid_q, stop_q, send_q, rlast_q;
  logic       load;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !pend_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        pend_q      <= q_valid_i && q_entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        byte_q   <= pend_byte_q;
        bvalid_q <= 1'b1;
        stop_q   <= 1'b0;
        send_q   <= pend_fin_q;
        rlast_q  <= 1'b1;
      end else begin
        byte_q      <= q_entry_i.byte0;
        bvalid_q    <= q_entry_i.valid0;
        stop_q      <= q_entry_i.stop0;
        send_q      <= q_entry_i.fin && !q_entry_i.two;
        rlast_q     <= !q_entry_i.two;
        pend_byte_q <= q_entry_i.byte1;
        pend_fin_q  <= q_entry_i.fin;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign stop_seen_o  = stop_q;
  assign string_end_o = send_q;
  assign run_last_o   = rlast_q;

endmodule

### rtl/core/backslash_escape_decoder.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes backslash escapes in a byte stream, one input byte per cycle.
// ----------------------------------------------------------------------------
// usage
//   slave channel: one string byte per request in tdata, tlast on the last
//   byte of the string
//   master channel: decoded results; tdata holds the byte and the run-last
//   flag, tuser says whether the byte is valid and whether a stop escape
//   was seen, tlast closes the string
//   each input byte gives zero, one or two results; the escape state is
//   updated as the byte is accepted, so a byte can be taken every cycle
//   first result of a byte is registered in the request queue, then in the output register
//   the output port moves one result per cycle while the receiver is ready;
//   bytes with two results (unknown escapes, digit runs ended by a plain byte)
//   send them in turn, and a request queue of QueueDepth entries absorbs the surplus
//   when the receiver stalls, the output register holds and the queue fills;
//   tready drops only once the queue is full
//   reset clears the escape state, the queue and the output register
// ----------------------------------------------------------------------------
module backslash_escape_decoder #(
  parameter int unsigned QueueDepth = bsed_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bsed_pkg::SDataW-1:0] s_axis_tdata_i,  // in_byte
  input  logic                        s_axis_tlast_i,  // is_final
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bsed_pkg::MDataW-1:0] m_axis_tdata_o,  // out_byte, run_last, zero pad
  output logic [bsed_pkg::MUserW-1:0] m_axis_tuser_o,  // byte_valid, stop_seen
  output logic                        m_axis_tlast_o   // string_end
);
  import bsed_pkg::*;

  logic        push, q_full, pop, q_valid;
  bsed_entry_t push_entry, pop_entry;
  logic [7:0]  out_byte;
  logic        byte_valid, stop_seen, run_last;

  bsed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_final_i (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  bsed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (pop_entry)
  );

  bsed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .stop_seen_o  (stop_seen),
    .string_end_o (m_axis_tlast_o),
    .run_last_o   (run_last)
  );

  assign m_axis_tdata_o = {7'b0, run_last, out_byte};
  assign m_axis_tuser_o = {stop_seen, byte_valid};

endmodule

### rtl/core/bsed_checker.sv
// ----------------------------------------------------------------------------
// bsed_checker
// Port-level checks of the backslash escape decoder.
// ----------------------------------------------------------------------------
module bsed_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [bsed_pkg::MDataW-1:0] m_axis_tdata_o,
  input logic [bsed_pkg::MUserW-1:0] m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);
  import bsed_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // second result of a byte follows its first without a gap
  a_pair_tight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tdata_o[8] |=> m_axis_tvalid_o)
    else $error("second result of a byte not ready");

endmodule

bind backslash_escape_decoder bsed_checker u_bsed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### sim/backslash_escape_decoder_tb.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_tb
// Sends strings into the escape decoder one byte per request and checks
// every decoded result. The checker compares each result, field by field,
// with an in-bench model of the escape state machine. Stimulus covers the
// escapes, octal and hex digit runs, unknown and stop escapes, and noise.
// The sender idles in bursts and the receiver stalls, including one long
// hold that fills the request queue of the block.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;

  import bsed_pkg::*;

  typedef enum logic [2:0] {
    ModeText    = 3'd0,
    ModeEscape  = 3'd1,
    ModeOctal   = 3'd2,
    ModeHex     = 3'd3,
    ModeStopped = 3'd4
  } decode_mode_e;

  typedef enum int {
    RxAlways,
    RxRandom,
    RxPattern
  } rx_style_e;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       stop;
    logic       str_end;
    logic       run_last;
  } decoded_t;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] Ch0         = "0";
  localparam logic [7:0] Ch7         = "7";
  localparam logic [7:0] Ch9         = "9";
  localparam logic [7:0] ChLowA      = "a";
  localparam logic [7:0] ChLowB      = "b";
  localparam logic [7:0] ChLowC      = "c";
  localparam logic [7:0] ChLowF      = "f";
  localparam logic [7:0] ChLowN      = "n";
  localparam logic [7:0] ChLowR      = "r";
  localparam logic [7:0] ChLowT      = "t";
  localparam logic [7:0] ChLowV      = "v";
  localparam logic [7:0] ChLowX      = "x";
  localparam logic [7:0] ChUpA       = "A";
  localparam logic [7:0] ChUpF       = "F";

  localparam logic [7:0] CodeBell      = 8'h07;
  localparam logic [7:0] CodeBackspace = 8'h08;
  localparam logic [7:0] CodeTab       = 8'h09;
  localparam logic [7:0] CodeNewline   = 8'h0A;
  localparam logic [7:0] CodeVtab      = 8'h0B;
  localparam logic [7:0] CodeFormfeed  = 8'h0C;
  localparam logic [7:0] CodeReturn    = 8'h0D;

  localparam int MaxPrinted = 40;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [SDataW-1:0] s_data  = '0;
  logic              s_last  = 1'b0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [MDataW-1:0] m_data;
  logic [MUserW-1:0] m_user;
  logic              m_last;

  backslash_escape_decoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // in_byte
    .s_axis_tlast_i  (s_last),   // is_final
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // out_byte, run_last, zero pad
    .m_axis_tuser_o  (m_user),   // byte_valid, stop_seen
    .m_axis_tlast_o  (m_last)    // string_end
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state as seen by the model
  decode_mode_e mode_q    = ModeText;
  logic [1:0]   run_count = 2'd0;
  logic [7:0]   run_value = 8'h00;
  decoded_t     step_out[$];
  decoded_t     decoded_q[$];

  logic [7:0]   text_buf[$];
  int           error_count = 0;
  int           sent_count  = 0;
  int           burst_left  = 0;
  int           gap_max     = 0;
  rx_style_e    rx_style    = RxAlways;
  int           rx_hold     = 0;
  logic [15:0]  rx_cycle    = '0;

  function automatic void add_out(input logic [7:0] ch, input logic vld, input logic stp);
    decoded_t r;
    r.data     = vld ? ch : 8'h00;
    r.valid    = vld;
    r.stop     = stp;
    r.str_end  = 1'b0;
    r.run_last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void take_text(input logic [7:0] ch, input logic fin);
    if (ch == ChBackslash && !fin) begin
      mode_q = ModeEscape;
    end else begin
      mode_q = ModeText;
      add_out(ch, 1'b1, 1'b0);
    end
  endfunction

  function automatic int digit_of(input logic [7:0] ch, input logic octal);
    if (octal) return (ch >= Ch0 && ch <= Ch7) ? int'(ch - Ch0) : -1;
    if (ch >= Ch0 && ch <= Ch9) return int'(ch - Ch0);
    if (ch >= ChLowA && ch <= ChLowF) return int'(ch - ChLowA) + 10;
    if (ch >= ChUpA && ch <= ChUpF) return int'(ch - ChUpA) + 10;
    return -1;
  endfunction

  function automatic void take_escape(input logic [7:0] ch, input logic fin);
    mode_q = ModeText;
    case (ch)
      ChBackslash: add_out(ChBackslash, 1'b1, 1'b0);
      ChLowA:      add_out(CodeBell, 1'b1, 1'b0);
      ChLowB:      add_out(CodeBackspace, 1'b1, 1'b0);
      ChLowF:      add_out(CodeFormfeed, 1'b1, 1'b0);
      ChLowN:      add_out(CodeNewline, 1'b1, 1'b0);
      ChLowR:      add_out(CodeReturn, 1'b1, 1'b0);
      ChLowT:      add_out(CodeTab, 1'b1, 1'b0);
      ChLowV:      add_out(CodeVtab, 1'b1, 1'b0);
      ChLowC: begin
        mode_q = ModeStopped;
        add_out(8'h00, 1'b0, 1'b1);
      end
      Ch0, ChLowX: begin
        mode_q    = (ch == Ch0) ? ModeOctal : ModeHex;
        run_count = 2'd0;
        run_value = 8'h00;
        if (fin) add_out(8'h00, 1'b1, 1'b0);
      end
      default: begin
        // unknown escape passes through with its backslash
        add_out(ChBackslash, 1'b1, 1'b0);
        add_out(ch, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic void take_digit(input logic [7:0] ch, input logic fin, input logic octal);
    int d;
    d = digit_of(ch, octal);
    if (d >= 0) begin
      run_value = octal ? 8'((run_value << 3) + d) : 8'((run_value << 4) + d);
      run_count = run_count + 2'd1;
      if (run_count >= (octal ? 2'd3 : 2'd2) || fin) begin
        mode_q = ModeText;
        add_out(run_value, 1'b1, 1'b0);
      end
    end else begin
      mode_q = ModeText;
      add_out(run_value, 1'b1, 1'b0);
      take_text(ch, fin);
    end
  endfunction

  function automatic void predict_request(input logic [7:0] ch, input logic fin);
    step_out.delete();
    case (mode_q)
      ModeStopped: if (fin) add_out(8'h00, 1'b0, 1'b0);
      ModeEscape:  take_escape(ch, fin);
      ModeOctal:   take_digit(ch, fin, 1'b1);
      ModeHex:     take_digit(ch, fin, 1'b0);
      default:     take_text(ch, fin);
    endcase
    if (fin) begin
      mode_q    = ModeText;
      run_count = 2'd0;
      run_value = 8'h00;
      if (step_out.size() > 0) step_out[step_out.size()-1].str_end = 1'b1;
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].run_last = 1'b1;
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result();
    decoded_t e;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                m_data, m_user, m_last));
      return;
    end
    e = decoded_q.pop_front();
    if (m_data[7:0] !== e.data)
      report_mismatch($sformatf("out_byte %h, want %h", m_data[7:0], e.data));
    if (m_data[8] !== e.run_last)
      report_mismatch($sformatf("run_last %b, want %b", m_data[8], e.run_last));
    if (m_data[MDataW-1:9] !== '0)
      report_mismatch($sformatf("tdata pad %h not zero", m_data[MDataW-1:9]));
    if (m_user[0] !== e.valid)
      report_mismatch($sformatf("byte_valid %b, want %b", m_user[0], e.valid));
    if (m_user[1] !== e.stop)
      report_mismatch($sformatf("stop_seen %b, want %b", m_user[1], e.stop));
    if (m_last !== e.str_end)
      report_mismatch($sformatf("string_end %b, want %b", m_last, e.str_end));
  endtask

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) check_result();
  end

  // receiver stall pattern, with an optional long hold counted here
  initial begin
    forever begin
      @(posedge clk);
      rx_cycle = rx_cycle + 16'd1;
      if (rx_hold > 0) begin
        m_ready <= 1'b0;
        rx_hold--;
      end else begin
        case (rx_style)
          RxAlways: m_ready <= 1'b1;
          RxRandom: m_ready <= ($urandom_range(0, 9) > 2);
          default:  m_ready <= !(rx_cycle[2:0] == 3'd5 || (rx_cycle[5:4] == 2'b11 && rx_cycle[0]));
        endcase
      end
    end
  end

  task automatic send_request(input logic [7:0] ch, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= fin;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_request(ch, fin);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_request(text_buf[i], i == text_buf.size() - 1);
  endtask

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'(Ch0 + d);
    return $urandom_range(0, 1) ? 8'(ChLowA + d - 10) : 8'(ChUpA + d - 10);
  endfunction

  function automatic logic [7:0] known_letter();
    case ($urandom_range(0, 7))
      0:       return ChBackslash;
      1:       return ChLowA;
      2:       return ChLowB;
      3:       return ChLowF;
      4:       return ChLowN;
      5:       return ChLowR;
      6:       return ChLowT;
      default: return ChLowV;
    endcase
  endfunction

  function automatic void build_string();
    int         n_tok;
    logic [7:0] ch;
    text_buf.delete();
    n_tok = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          ch = 8'($urandom_range(0, 255));
          text_buf.push_back(ch == ChBackslash ? ChLowA : ch);
        end
        2: begin
          text_buf.push_back(ChBackslash);
          text_buf.push_back(known_letter());
        end
        3: begin
          text_buf.push_back(ChBackslash);
          text_buf.push_back(Ch0);
          repeat ($urandom_range(0, 3)) text_buf.push_back(8'(Ch0 + $urandom_range(0, 7)));
        end
        4: begin
          text_buf.push_back(ChBackslash);
          text_buf.push_back(ChLowX);
          repeat ($urandom_range(0, 2)) text_buf.push_back(hex_char());
        end
        5: begin
          text_buf.push_back(ChBackslash);
          text_buf.push_back(8'($urandom_range(0, 255)));
        end
        6: begin
          if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back(ChBackslash);
            text_buf.push_back(ChLowC);
          end else begin
            text_buf.push_back(hex_char());
          end
        end
        7: text_buf.push_back(8'($urandom_range(0, 255)));
        default: text_buf.push_back(hex_char());
      endcase
    end
  endfunction

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0:       rx_style = RxAlways;
      1:       rx_style = RxRandom;
      default: rx_style = RxPattern;
    endcase
    case ($urandom_range(0, 2))
      0:       gap_max = 0;
      1:       gap_max = 2;
      default: gap_max = 8;
    endcase
  endtask

  task automatic test_directed_escapes();
    rx_style = RxAlways;
    gap_max  = 0;
    // zero byte, unknown escape, all ones, lone trailing backslash
    text_buf = '{8'h00, ChBackslash, "q", 8'hFF, ChBackslash};
    send_text();
    // hex run ended by a plain byte, full octal run wrapping past 8 bits
    text_buf = '{ChBackslash, ChLowX, "4", "G", ChBackslash, Ch0, Ch7, Ch7, Ch7, "5"};
    send_text();
    // stop escape in the middle, then an empty hex run at string end
    text_buf = '{ChBackslash, ChLowC, "z"};
    send_text();
    text_buf = '{ChBackslash, ChLowX};
    send_text();
    text_buf = '{ChBackslash, ChLowA, ChBackslash, ChLowB, ChBackslash, ChLowF,
                 ChBackslash, ChLowN, ChBackslash, ChLowR, ChBackslash, ChLowT,
                 ChBackslash, ChLowV, ChBackslash, ChBackslash};
    send_text();
  endtask

  task automatic test_random_strings(input int target);
    int stop_at;
    stop_at = sent_count + target;
    pick_idling();
    while (sent_count < stop_at) begin
      build_string();
      send_text();
      if ($urandom_range(0, 3) == 0) pick_idling();
    end
  endtask

  task automatic test_full_queue();
    int stop_at;
    stop_at  = sent_count + 80;
    gap_max  = 0;
    rx_style = RxRandom;
    rx_hold  = 400;
    while (sent_count < stop_at) begin
      build_string();
      send_text();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_escapes();
    test_random_strings(300);
    test_full_queue();
    test_random_strings(300);
    s_valid  <= 1'b0;
    rx_style = RxAlways;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", decoded_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
